// File: rtl/core/billboard_quad_corners_assert.svh
// Assertion macros for the billboard quad corner block.
`ifndef BILLBOARD_QUAD_CORNERS_ASSERT_SVH
`define BILLBOARD_QUAD_CORNERS_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BQC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bqc assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define BQC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqc assertion failed");

`endif

// File: rtl/core/bqc_pkg.sv
// Shared types and constants for the billboard quad corner block.
package bqc_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = COORD_W - 1;
  localparam int SIZE_W  = 24;
  localparam int RAD_W   = 2 * COORD_W;
  localparam int ROOT_W  = COORD_W;
  localparam int QUO_W   = SIZE_W;
  localparam int NUM_W   = QUO_W + ROOT_W + 1;
  localparam int TERM_W  = SIZE_W + 2;
  localparam int SUM_W   = COORD_W + 2;

  // One request after the facing has been normalized.
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      nx;
    logic                      ny;
    logic                      nz;
    logic [MAG_W-1:0]          ax;
    logic [MAG_W-1:0]          ay;
    logic [MAG_W-1:0]          az;
    logic [SIZE_W-1:0]         s;
    logic                      axis;
  } item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {F_IDLE, F_NORM, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SQ, B_RSTART, B_ROOT, B_MUL, B_DSTART, B_DWAIT, B_EMIT
  } back_state_t;

  typedef enum logic [2:0] {OP_P, OP_Q, OP_V0, OP_V1, OP_V2} div_op_t;

endpackage

// File: rtl/core/bqc_front.sv
// Front end: takes requests, forms facing magnitudes and normalizes them.
module bqc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_center_y,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_center_z,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_facing_x,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_facing_y,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_facing_z,
  input  logic [bqc_pkg::SIZE_W-1:0]         in_half_size,
  input  logic                              q_full,
  output logic                              busy,
  output logic                              push,
  output bqc_pkg::item_t                    push_item
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  bqc_pkg::front_state_t state_r, state_nxt;
  logic [2:0]                 step_r;
  bqc_pkg::item_t             item_r;
  logic [bqc_pkg::MAG_W-1:0]  mx_r;

  logic [bqc_pkg::COORD_W-1:0] mag_x, mag_y, mag_z, mag_m;
  logic [bqc_pkg::MAG_W-1:0]   sh_x, sh_y, sh_z, sh_m;
  logic                        accept;
  logic                        do_shift;
  logic [4:0]                  amt;

  assign accept = start && (state_r == bqc_pkg::F_IDLE);

  // Magnitudes of the facing; the only value that needs a right shift is 2^31.
  always_comb begin
    mag_x = in_facing_x[bqc_pkg::COORD_W-1] ? (~in_facing_x + 1'b1) : in_facing_x;
    mag_y = in_facing_y[bqc_pkg::COORD_W-1] ? (~in_facing_y + 1'b1) : in_facing_y;
    mag_z = in_facing_z[bqc_pkg::COORD_W-1] ? (~in_facing_z + 1'b1) : in_facing_z;
    mag_m = mag_x;
    if (mag_y > mag_m) begin
      mag_m = mag_y;
    end
    if (mag_z > mag_m) begin
      mag_m = mag_z;
    end
    if (mag_m[bqc_pkg::COORD_W-1]) begin
      sh_x = mag_x[bqc_pkg::COORD_W-1:1];
      sh_y = mag_y[bqc_pkg::COORD_W-1:1];
      sh_z = mag_z[bqc_pkg::COORD_W-1:1];
      sh_m = mag_m[bqc_pkg::COORD_W-1:1];
    end else begin
      sh_x = mag_x[bqc_pkg::MAG_W-1:0];
      sh_y = mag_y[bqc_pkg::MAG_W-1:0];
      sh_z = mag_z[bqc_pkg::MAG_W-1:0];
      sh_m = mag_m[bqc_pkg::MAG_W-1:0];
    end
  end

  // Binary search for the left shift that puts the largest magnitude at bit 30.
  always_comb begin
    case (step_r)
      3'd0: begin
        amt      = 5'd16;
        do_shift = (mx_r[30:15] == '0);
      end
      3'd1: begin
        amt      = 5'd8;
        do_shift = (mx_r[30:23] == '0);
      end
      3'd2: begin
        amt      = 5'd4;
        do_shift = (mx_r[30:27] == '0);
      end
      3'd3: begin
        amt      = 5'd2;
        do_shift = (mx_r[30:29] == '0);
      end
      3'd4: begin
        amt      = 5'd1;
        do_shift = !mx_r[30];
      end
      default: begin
        amt      = 5'd0;
        do_shift = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bqc_pkg::F_IDLE: begin
        if (start) begin
          state_nxt = bqc_pkg::F_NORM;
        end
      end
      bqc_pkg::F_NORM: begin
        if (step_r == LAST_STEP) begin
          state_nxt = bqc_pkg::F_PUSH;
        end
      end
      bqc_pkg::F_PUSH: begin
        if (!q_full) begin
          state_nxt = bqc_pkg::F_IDLE;
        end
      end
      default: state_nxt = bqc_pkg::F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy = (state_r != bqc_pkg::F_IDLE);
    push = (state_r == bqc_pkg::F_PUSH) && !q_full;
  end

  assign push_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqc_pkg::F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r <= '0;
      end else if (state_r == bqc_pkg::F_NORM) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  // Request payload and normalization shifts.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cx   <= in_center_x;
      item_r.cy   <= in_center_y;
      item_r.cz   <= in_center_z;
      item_r.nx   <= in_facing_x[bqc_pkg::COORD_W-1];
      item_r.ny   <= in_facing_y[bqc_pkg::COORD_W-1];
      item_r.nz   <= in_facing_z[bqc_pkg::COORD_W-1];
      item_r.ax   <= sh_x;
      item_r.ay   <= sh_y;
      item_r.az   <= sh_z;
      item_r.s    <= in_half_size;
      item_r.axis <= (sh_y == '0) && (sh_z == '0);
      mx_r        <= sh_m;
    end else if ((state_r == bqc_pkg::F_NORM) && do_shift) begin
      item_r.ax <= item_r.ax << amt;
      item_r.ay <= item_r.ay << amt;
      item_r.az <= item_r.az << amt;
      mx_r      <= mx_r << amt;
    end
  end

endmodule

// File: rtl/core/bqc_queue.sv
// Two-entry queue between the front end and the back end.
module bqc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bqc_pkg::item_t   push_item,
  input  logic             pop,
  output bqc_pkg::item_t   head,
  output bqc_pkg::q_stat_t stat
);

  bqc_pkg::item_t ent_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/bqc_isqrt.sv
// Integer square root, one result bit per cycle.
module bqc_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bqc_pkg::RAD_W-1:0]   rad,
  output logic                        busy,
  output logic [bqc_pkg::ROOT_W-1:0]  root
);

  logic                        busy_r;
  logic [4:0]                  cnt_r;
  logic [bqc_pkg::RAD_W-1:0]   rad_r;
  logic [33:0]                 rem_r;
  logic [bqc_pkg::ROOT_W-1:0]  root_r;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  assign busy = busy_r;
  assign root = root_r;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_r, rad_r[bqc_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (fits) begin
        rem_r  <= 34'(rem_sh - trial);
        root_r <= {root_r[bqc_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[33:0];
        root_r <= {root_r[bqc_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/bqc_div.sv
// Restoring divider, one quotient bit per cycle; the quotient is known to fit 24 bits.
module bqc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bqc_pkg::NUM_W-1:0]   num,
  input  logic [bqc_pkg::ROOT_W-1:0]  den,
  output logic                        busy,
  output logic [bqc_pkg::QUO_W-1:0]   quo
);

  logic                        busy_r;
  logic [4:0]                  cnt_r;
  logic [bqc_pkg::ROOT_W-1:0]  rem_r;
  logic [bqc_pkg::ROOT_W-1:0]  den_r;
  logic [bqc_pkg::QUO_W-1:0]   nq_r;

  logic [bqc_pkg::ROOT_W:0] rem_sh;
  logic                     fits;

  assign busy = busy_r;
  assign quo  = nq_r;

  // Low numerator bits shift out as quotient bits shift in.
  always_comb begin
    rem_sh = {rem_r, nq_r[bqc_pkg::QUO_W-1]};
    fits   = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(bqc_pkg::QUO_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[bqc_pkg::NUM_W-2:bqc_pkg::QUO_W];
      nq_r  <= num[bqc_pkg::QUO_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= bqc_pkg::ROOT_W'(rem_sh - {1'b0, den_r});
      end else begin
        rem_r <= rem_sh[bqc_pkg::ROOT_W-1:0];
      end
      nq_r <= {nq_r[bqc_pkg::QUO_W-2:0], fits};
    end
  end

endmodule

// File: rtl/core/bqc_back.sv
// Back end: edge vector math with shared multiplier, roots and divider, then corner output.
module bqc_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bqc_pkg::q_stat_t                   q_stat,
  input  bqc_pkg::item_t                     head,
  output logic                               pop,
  output logic                               out_valid,
  output logic signed [bqc_pkg::COORD_W-1:0] out_corner_x,
  output logic signed [bqc_pkg::COORD_W-1:0] out_corner_y,
  output logic signed [bqc_pkg::COORD_W-1:0] out_corner_z,
  output logic [1:0]                         out_corner_index,
  output logic                               out_last_corner,
  output logic                               out_saturated
);

  localparam logic signed [bqc_pkg::SUM_W-1:0] CMAX =
    bqc_pkg::SUM_W'((64'sd1 <<< (bqc_pkg::COORD_W - 1)) - 64'sd1);
  localparam logic signed [bqc_pkg::SUM_W-1:0] CMIN = -CMAX - 1;

  bqc_pkg::back_state_t state_r, state_nxt;
  bqc_pkg::div_op_t     op_r;
  logic [1:0]           cnt_r;
  bqc_pkg::item_t       it_r;
  logic [63:0]          prod_r;
  logic [62:0]          m2_r;
  logic [63:0]          d2_r;
  logic [bqc_pkg::QUO_W-1:0] p_r, q_r, v0_r, v1_r, v2_r;

  logic                               out_valid_r;
  logic signed [bqc_pkg::COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [1:0]                         idx_r;
  logic                               last_r;
  logic                               sat_r;

  logic [31:0] mul_a, mul_b;
  logic        root_start;
  logic        rm_busy, rd_busy;
  logic [bqc_pkg::ROOT_W-1:0] root_m, root_d;
  logic        div_start;
  logic        div_busy;
  logic [bqc_pkg::QUO_W-1:0] div_quo;
  logic [bqc_pkg::ROOT_W-1:0] den;
  logic [bqc_pkg::NUM_W-1:0]  num;

  logic signed [bqc_pkg::TERM_W-1:0] uy, uz, vx, vy, vz;
  logic signed [bqc_pkg::TERM_W-1:0] tux, tuy, tuz, tvx, tvy, tvz;
  logic signed [bqc_pkg::SUM_W-1:0]  sx, sy, sz;
  logic                              su_pos, sv_pos;
  logic signed [bqc_pkg::COORD_W-1:0] kx, ky, kz;
  logic                              ox, oy, oz;

  // Saturate a full-width sum to the coordinate range.
  function automatic logic signed [bqc_pkg::COORD_W:0] clamp(
    input logic signed [bqc_pkg::SUM_W-1:0] v
  );
    logic signed [bqc_pkg::COORD_W-1:0] r;
    logic                               o;
    begin
      o = 1'b0;
      r = v[bqc_pkg::COORD_W-1:0];
      if (v > CMAX) begin
        r = CMAX[bqc_pkg::COORD_W-1:0];
        o = 1'b1;
      end else if (v < CMIN) begin
        r = CMIN[bqc_pkg::COORD_W-1:0];
        o = 1'b1;
      end
      clamp = {o, r};
    end
  endfunction

  bqc_isqrt u_root_m (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .rad   ({1'b0, m2_r}),
    .busy  (rm_busy),
    .root  (root_m)
  );

  bqc_isqrt u_root_d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .rad   (d2_r),
    .busy  (rd_busy),
    .root  (root_d)
  );

  bqc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == bqc_pkg::B_SQ) begin
      case (cnt_r)
        2'd0: begin
          mul_a = {1'b0, it_r.ay};
          mul_b = {1'b0, it_r.ay};
        end
        2'd1: begin
          mul_a = {1'b0, it_r.az};
          mul_b = {1'b0, it_r.az};
        end
        2'd2: begin
          mul_a = {1'b0, it_r.ax};
          mul_b = {1'b0, it_r.ax};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else begin
      case (op_r)
        bqc_pkg::OP_P: begin
          mul_a = 32'(it_r.s);
          mul_b = {1'b0, it_r.az};
        end
        bqc_pkg::OP_Q: begin
          mul_a = 32'(it_r.s);
          mul_b = {1'b0, it_r.ay};
        end
        bqc_pkg::OP_V0: begin
          mul_a = 32'(it_r.s);
          mul_b = root_m;
        end
        bqc_pkg::OP_V1: begin
          mul_a = 32'(q_r);
          mul_b = {1'b0, it_r.ax};
        end
        bqc_pkg::OP_V2: begin
          mul_a = 32'(p_r);
          mul_b = {1'b0, it_r.ax};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // Rounded division: add half the divisor to the product.
  always_comb begin
    if ((op_r == bqc_pkg::OP_P) || (op_r == bqc_pkg::OP_Q)) begin
      den = root_m;
    end else begin
      den = root_d;
    end
    num = {1'b0, prod_r[bqc_pkg::NUM_W-2:0]} + bqc_pkg::NUM_W'(den >> 1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bqc_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = head.axis ? bqc_pkg::B_EMIT : bqc_pkg::B_SQ;
        end
      end
      bqc_pkg::B_SQ: begin
        if (cnt_r == 2'd3) begin
          state_nxt = bqc_pkg::B_RSTART;
        end
      end
      bqc_pkg::B_RSTART: state_nxt = bqc_pkg::B_ROOT;
      bqc_pkg::B_ROOT: begin
        if (!rm_busy && !rd_busy) begin
          state_nxt = bqc_pkg::B_MUL;
        end
      end
      bqc_pkg::B_MUL:    state_nxt = bqc_pkg::B_DSTART;
      bqc_pkg::B_DSTART: state_nxt = bqc_pkg::B_DWAIT;
      bqc_pkg::B_DWAIT: begin
        if (!div_busy) begin
          state_nxt = (op_r == bqc_pkg::OP_V2) ? bqc_pkg::B_EMIT : bqc_pkg::B_MUL;
        end
      end
      bqc_pkg::B_EMIT: begin
        if (cnt_r == 2'd3) begin
          state_nxt = bqc_pkg::B_IDLE;
        end
      end
      default: state_nxt = bqc_pkg::B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop        = (state_r == bqc_pkg::B_IDLE) && !q_stat.empty;
    root_start = (state_r == bqc_pkg::B_RSTART);
    div_start  = (state_r == bqc_pkg::B_DSTART);
  end

  // Signed edge components.
  always_comb begin
    if (it_r.axis) begin
      uy = bqc_pkg::TERM_W'(it_r.s);
      uz = '0;
      vx = '0;
      vy = '0;
      vz = bqc_pkg::TERM_W'(it_r.s);
    end else begin
      uy = it_r.nz ? -bqc_pkg::TERM_W'(p_r) : bqc_pkg::TERM_W'(p_r);
      uz = it_r.ny ? bqc_pkg::TERM_W'(q_r) : -bqc_pkg::TERM_W'(q_r);
      vx = bqc_pkg::TERM_W'(v0_r);
      vy = (it_r.nx == it_r.ny) ? -bqc_pkg::TERM_W'(v1_r) : bqc_pkg::TERM_W'(v1_r);
      vz = (it_r.nx == it_r.nz) ? -bqc_pkg::TERM_W'(v2_r) : bqc_pkg::TERM_W'(v2_r);
    end
  end

  // Corner sums for the corner now being sent.
  always_comb begin
    su_pos = cnt_r[1];
    sv_pos = cnt_r[0] ^ cnt_r[1];
    tux = '0;
    tuy = su_pos ? uy : -uy;
    tuz = su_pos ? uz : -uz;
    tvx = sv_pos ? vx : -vx;
    tvy = sv_pos ? vy : -vy;
    tvz = sv_pos ? vz : -vz;
    sx = bqc_pkg::SUM_W'(it_r.cx) + bqc_pkg::SUM_W'(tux) + bqc_pkg::SUM_W'(tvx);
    sy = bqc_pkg::SUM_W'(it_r.cy) + bqc_pkg::SUM_W'(tuy) + bqc_pkg::SUM_W'(tvy);
    sz = bqc_pkg::SUM_W'(it_r.cz) + bqc_pkg::SUM_W'(tuz) + bqc_pkg::SUM_W'(tvz);
    {ox, kx} = clamp(sx);
    {oy, ky} = clamp(sy);
    {oz, kz} = clamp(sz);
  end

  // Control registers; the step count wraps from three to zero on its own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bqc_pkg::B_IDLE;
      cnt_r       <= '0;
      op_r        <= bqc_pkg::OP_P;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == bqc_pkg::B_EMIT);
      if (pop) begin
        cnt_r <= '0;
        op_r  <= bqc_pkg::OP_P;
      end else if ((state_r == bqc_pkg::B_SQ) || (state_r == bqc_pkg::B_EMIT)) begin
        cnt_r <= cnt_r + 2'd1;
      end
      if ((state_r == bqc_pkg::B_DWAIT) && !div_busy) begin
        case (op_r)
          bqc_pkg::OP_P:  op_r <= bqc_pkg::OP_Q;
          bqc_pkg::OP_Q:  op_r <= bqc_pkg::OP_V0;
          bqc_pkg::OP_V0: op_r <= bqc_pkg::OP_V1;
          bqc_pkg::OP_V1: op_r <= bqc_pkg::OP_V2;
          default:        op_r <= bqc_pkg::OP_P;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (pop) begin
      it_r <= head;
    end
    if (state_r == bqc_pkg::B_SQ) begin
      case (cnt_r)
        2'd1:    m2_r <= 63'(prod_r);
        2'd2:    m2_r <= m2_r + 63'(prod_r);
        2'd3:    d2_r <= 64'(m2_r) + prod_r;
        default: m2_r <= m2_r;
      endcase
    end
    if ((state_r == bqc_pkg::B_DWAIT) && !div_busy) begin
      case (op_r)
        bqc_pkg::OP_P:  p_r  <= div_quo;
        bqc_pkg::OP_Q:  q_r  <= div_quo;
        bqc_pkg::OP_V0: v0_r <= div_quo;
        bqc_pkg::OP_V1: v1_r <= div_quo;
        default:        v2_r <= div_quo;
      endcase
    end
    if (state_r == bqc_pkg::B_EMIT) begin
      cx_r   <= kx;
      cy_r   <= ky;
      cz_r   <= kz;
      idx_r  <= cnt_r;
      last_r <= (cnt_r == 2'd3);
      sat_r  <= ox | oy | oz;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_corner_x     = cx_r;
  assign out_corner_y     = cy_r;
  assign out_corner_z     = cz_r;
  assign out_corner_index = idx_r;
  assign out_last_corner  = last_r;
  assign out_saturated    = sat_r;

endmodule

// File: rtl/core/billboard_quad_corners.sv
// Billboard quad corner generator: top level with front end, queue and back end.
// Each request gives four results on consecutive cycles, corner 0 to 3, one per out_valid
// strobe; the receiver cannot hold them off. A request is taken when start is high and busy
// is low; the front end then normalizes the facing by a binary search of left shifts and
// hands the request to a two-entry queue, so busy stays high until the queue takes it, and
// new requests are taken while earlier quads are still worked on. In the back end a quad
// whose facing has no y or z part left after the right shift of a 2^31 magnitude is taken
// from the queue and goes straight to output. Any other quad is taken from the queue, then
// squared on the shared multiplier, then the bit-serial square roots are started and run to
// the end, then five rounded divisions go through the one bit-serial divider, which sets the
// sustained rate, before the four corners are sent.
module billboard_quad_corners (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_center_y,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_center_z,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_facing_x,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_facing_y,
  input  logic signed [bqc_pkg::COORD_W-1:0] in_facing_z,
  input  logic [bqc_pkg::SIZE_W-1:0]         in_half_size,
  output logic                               out_valid,
  output logic signed [bqc_pkg::COORD_W-1:0] out_corner_x,
  output logic signed [bqc_pkg::COORD_W-1:0] out_corner_y,
  output logic signed [bqc_pkg::COORD_W-1:0] out_corner_z,
  output logic [1:0]                         out_corner_index,
  output logic                               out_last_corner,
  output logic                               out_saturated
);

`include "billboard_quad_corners_assert.svh"

  logic             q_push;
  logic             q_pop;
  bqc_pkg::item_t   push_item;
  bqc_pkg::item_t   head;
  bqc_pkg::q_stat_t q_stat;

  bqc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_center_z  (in_center_z),
    .in_facing_x  (in_facing_x),
    .in_facing_y  (in_facing_y),
    .in_facing_z  (in_facing_z),
    .in_half_size (in_half_size),
    .q_full       (q_stat.full),
    .busy         (busy),
    .push         (q_push),
    .push_item    (push_item)
  );

  bqc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  bqc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head             (head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_corner_z     (out_corner_z),
    .out_corner_index (out_corner_index),
    .out_last_corner  (out_last_corner),
    .out_saturated    (out_saturated)
  );

  // A quad's corners leave on consecutive cycles, and the last flag marks corner three.
  `BQC_ASSERT_NEXT(a_corner_run, out_valid && (out_corner_index == 2'd0), out_valid && (out_corner_index == 2'd1))
  `BQC_ASSERT_NOW(a_last_flag, out_valid, out_last_corner == (out_corner_index == 2'd3))
  // The queue never takes a request when full unless one leaves in the same cycle, and never gives one when empty.
  `BQC_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full || q_pop)
  `BQC_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the billboard quad corner generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One quad request plus the sender's idle cycles before it and a flag to drain first.
  typedef struct {
    logic signed [bqc_pkg::COORD_W-1:0] cx, cy, cz, fx, fy, fz;
    logic [bqc_pkg::SIZE_W-1:0] size;
    int unsigned gap;
    bit drain;
  } quad_req_t;

  // One corner as the block should deliver it.
  typedef struct {
    logic signed [bqc_pkg::COORD_W-1:0] x, y, z;
    logic [1:0] idx;
    logic last;
    logic sat;
  } corner_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [bqc_pkg::COORD_W-1:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [bqc_pkg::COORD_W-1:0] in_facing_x = '0, in_facing_y = '0, in_facing_z = '0;
  logic [bqc_pkg::SIZE_W-1:0] in_half_size = '0;
  logic out_valid;
  logic signed [bqc_pkg::COORD_W-1:0] out_corner_x, out_corner_y, out_corner_z;
  logic [1:0] out_corner_index;
  logic out_last_corner, out_saturated;

  quad_req_t pending_quads[$];
  corner_t expected_corners[$];
  quad_req_t cur_quad;
  int unsigned gap_left = 0;
  int unsigned mismatches = 0;
  bit stim_done = 1'b0;

  billboard_quad_corners dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Integer square root, floor.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Division rounding half up; a zero divisor gives zero.
  function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
    return (d == 0) ? 64'd0 : (n + d / 2) / d;
  endfunction

  function automatic longint signed signed_mag(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Work out the four corners of a quad and queue them.
  function automatic void predict_corners(quad_req_t q);
    longint signed c[3], d[3], u[3], v[3], r, hi, lo, su, sv;
    longint unsigned s, ax, ay, az, mx, m2, m, dd, p, qq;
    corner_t cr;
    s = q.size;
    c[0] = q.cx; c[1] = q.cy; c[2] = q.cz;
    d[0] = q.fx; d[1] = q.fy; d[2] = q.fz;
    u = '{0, longint'(s), 0};
    v = '{0, 0, longint'(s)};
    if (d[1] != 0 || d[2] != 0) begin
      ax = (d[0] < 0) ? -d[0] : d[0];
      ay = (d[1] < 0) ? -d[1] : d[1];
      az = (d[2] < 0) ? -d[2] : d[2];
      mx = ax;
      if (ay > mx) mx = ay;
      if (az > mx) mx = az;
      // Bring the largest magnitude into [2^30, 2^31).
      while (mx >= (64'd1 << 31)) begin
        ax >>= 1; ay >>= 1; az >>= 1; mx >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
        ax <<= 1; ay <<= 1; az <<= 1; mx <<= 1;
      end
      // A tiny y and z lost in the shift falls back to the axis edges.
      if (ay != 0 || az != 0) begin
        m2 = ay * ay + az * az;
        m = floor_sqrt(m2);
        dd = floor_sqrt(ax * ax + m2);
        p = div_round(s * az, m);
        qq = div_round(s * ay, m);
        u[0] = 0;
        u[1] = signed_mag(p, d[2] < 0);
        u[2] = signed_mag(qq, !(d[1] < 0));
        v[0] = longint'(div_round(s * m, dd));
        v[1] = signed_mag(div_round(qq * ax, dd), !((d[0] < 0) != (d[1] < 0)));
        v[2] = signed_mag(div_round(p * ax, dd), !((d[0] < 0) != (d[2] < 0)));
      end
    end
    hi = (64'sd1 <<< (bqc_pkg::COORD_W - 1)) - 1;
    lo = -hi - 1;
    for (int k = 0; k < 4; k++) begin
      su = (k < 2) ? -1 : 1;
      sv = (k == 1 || k == 2) ? 1 : -1;
      cr.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        r = c[i] + su * u[i] + sv * v[i];
        if (r > hi) begin r = hi; cr.sat = 1'b1; end
        if (r < lo) begin r = lo; cr.sat = 1'b1; end
        if (i == 0) cr.x = r[bqc_pkg::COORD_W-1:0];
        else if (i == 1) cr.y = r[bqc_pkg::COORD_W-1:0];
        else cr.z = r[bqc_pkg::COORD_W-1:0];
      end
      cr.idx = k[1:0];
      cr.last = (k == 3);
      expected_corners.push_back(cr);
    end
  endfunction

  // Driver: predicts on each accepted request, then idles or presents the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) predict_corners(cur_quad);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_quads.size() == 0) begin
          start <= 1'b0;
        end else if (pending_quads[0].drain && expected_corners.size() != 0) begin
          start <= 1'b0;
        end else if (pending_quads[0].gap > 0) begin
          gap_left = pending_quads[0].gap - 1;
          pending_quads[0].gap = 0;
          start <= 1'b0;
        end else begin
          cur_quad = pending_quads.pop_front();
          in_center_x <= cur_quad.cx;
          in_center_y <= cur_quad.cy;
          in_center_z <= cur_quad.cz;
          in_facing_x <= cur_quad.fx;
          in_facing_y <= cur_quad.fy;
          in_facing_z <= cur_quad.fz;
          in_half_size <= cur_quad.size;
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each corner with the oldest expectation.
  always @(posedge clk) begin
    corner_t e;
    if (rst_n && out_valid) begin
      if (expected_corners.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected corner x=%0d y=%0d z=%0d idx=%0d",
                                       out_corner_x, out_corner_y, out_corner_z,
                                       out_corner_index);
      end else begin
        e = expected_corners.pop_front();
        if (out_corner_x !== e.x || out_corner_y !== e.y || out_corner_z !== e.z ||
            out_corner_index !== e.idx || out_last_corner !== e.last ||
            out_saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("corner mismatch: exp %0d %0d %0d i%0d l%0d s%0d got %0d %0d %0d i%0d l%0d s%0d",
                     e.x, e.y, e.z, e.idx, e.last, e.sat, out_corner_x, out_corner_y,
                     out_corner_z, out_corner_index, out_last_corner, out_saturated);
        end
      end
    end
  end

  function automatic void add_quad(longint cx, longint cy, longint cz, longint fx,
                                   longint fy, longint fz, longint size,
                                   int unsigned gap, bit drain);
    quad_req_t q;
    q.cx = cx[bqc_pkg::COORD_W-1:0];
    q.cy = cy[bqc_pkg::COORD_W-1:0];
    q.cz = cz[bqc_pkg::COORD_W-1:0];
    q.fx = fx[bqc_pkg::COORD_W-1:0];
    q.fy = fy[bqc_pkg::COORD_W-1:0];
    q.fz = fz[bqc_pkg::COORD_W-1:0];
    q.size = size[bqc_pkg::SIZE_W-1:0];
    q.gap = gap;
    q.drain = drain;
    pending_quads.push_back(q);
  endfunction

  // Random facing component: full range, small, zero, or full range scaled down by a shift.
  function automatic longint rand_comp();
    case ($urandom_range(0, 3))
      0: return longint'($signed($urandom()));
      1: return longint'($signed($urandom_range(0, 64))) - 32;
      2: return 0;
      default: return longint'($signed($urandom())) >>> $urandom_range(0, 30);
    endcase
  endfunction

  function automatic longint rand_center();
    if ($urandom_range(0, 1)) return longint'($signed($urandom()));
    return longint'($signed($urandom_range(0, 2000000))) - 1000000;
  endfunction

  // Stimulus and end of run.
  initial begin
    longint mx, mn;
    int unsigned g;
    bit busy_phase;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, axis facing, zero facing, tiny y/z lost in the shift, saturation.
    add_quad(0, 0, 0, 0, 0, 0, 256, 0, 0);
    add_quad(0, 0, 0, 1000, 0, 0, 16777215, 0, 0);
    add_quad(mx, mx, mx, 0, 0, 0, 16777215, 0, 0);
    add_quad(mn, mn, mn, 0, 0, 0, 16777215, 0, 0);
    add_quad(0, 0, 0, mn, 1, 0, 4096, 0, 0);
    add_quad(0, 0, 0, mx, 0, -1, 4096, 0, 0);
    add_quad(0, 0, 0, mn, mn, mn, 16777215, 0, 0);
    add_quad(0, 0, 0, mx, mx, mx, 16777215, 0, 0);
    add_quad(mx, mn, mx, 1, -1, 1, 16777215, 0, 0);
    add_quad(mn, mx, mn, -1, 1, -1, 16777215, 0, 0);
    add_quad(100, -100, 50, 0, 5, 0, 0, 0, 0);
    add_quad(100, -100, 50, 0, 0, -5, 16777215, 0, 0);
    add_quad(0, 0, 0, 3, 4, 0, 1280, 0, 0);
    add_quad(0, 0, 0, -7, 0, 24, 1, 0, 0);
    add_quad(mx, 0, mn, mn, mx, mn, 16777215, 0, 0);
    add_quad(-12345, 6789, 2222, -12345, 6789, 2222, 512, 0, 0);
    add_quad(-1, -1, -1, -1, -1, -1, 16777215, 0, 0);

    // Random part in phases, some with no sender idling.
    for (int n = 0; n < 500; n++) begin
      if (n % 50 == 0) busy_phase = $urandom_range(0, 2) != 0;
      g = busy_phase ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 7) == 0) begin
        mx = rand_center();
        add_quad(mx, rand_center(), rand_center(), mx >>> $urandom_range(0, 8),
                 rand_comp(), rand_comp(), $urandom_range(0, 16777215), g, n == 260);
      end else begin
        add_quad(rand_center(), rand_center(), rand_center(), rand_comp(), rand_comp(),
                 rand_comp(), $urandom_range(0, 3) == 0 ? $urandom_range(0, 16777215)
                 : $urandom_range(0, 65535), g, n == 260);
      end
    end

    wait (pending_quads.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (expected_corners.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bqc_pkg.sv
rtl/core/bqc_front.sv
rtl/core/bqc_queue.sv
rtl/core/bqc_isqrt.sv
rtl/core/bqc_div.sv
rtl/core/bqc_back.sv
rtl/core/billboard_quad_corners.sv
tb/testbench.sv
